// ----- rtl/core/skt_pkg.sv -----
// Shared types and constants of the sorted key table.
package skt_pkg;

  localparam int DEPTH        = 16;
  localparam int KEY_BITS     = 31;
  localparam int PAYLOAD_BITS = 16;
  localparam int IDX_BITS     = $clog2(DEPTH);
  localparam int TDATA_BITS   = ((KEY_BITS + PAYLOAD_BITS + 7) / 8) * 8;

  typedef logic [KEY_BITS-1:0]     key_t;
  typedef logic [PAYLOAD_BITS-1:0] payload_t;
  typedef logic [IDX_BITS-1:0]     idx_t;

  // command kinds on the input tuser
  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_FIND   = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_DUMP   = 2'd3
  } kind_t;

  // result status on the output tuser
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_EMPTY     = 2'd3
  } status_t;

  // operation broadcast to every cell of the row
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2
  } cell_op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // contents of one cell
  typedef struct packed {
    logic     valid;
    key_t     key;
    payload_t payload;
  } cell_data_t;

  // per-cell flags handed along the row
  typedef struct packed {
    logic ge;      // valid and key >= command key
    logic prefix;  // some cell at or before this one matches
  } cell_flags_t;

endpackage

// ----- rtl/core/skt_cell.sv -----
// One record cell: holds a key and payload, shifts right on insert, left on remove.
module skt_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  skt_pkg::cell_op_t   op,
  input  skt_pkg::key_t       cmd_key,
  input  skt_pkg::payload_t   cmd_payload,
  input  skt_pkg::cell_data_t left_data,
  input  skt_pkg::cell_flags_t left_flags,
  input  skt_pkg::cell_data_t right_data,
  output skt_pkg::cell_data_t cur_data,
  output skt_pkg::cell_flags_t cur_flags,
  output logic                match
);
  import skt_pkg::*;

  logic     valid_r, valid_nxt;
  key_t     key_r, key_nxt;
  payload_t payload_r, payload_nxt;
  logic     ge;

  assign ge    = valid_r && (key_r >= cmd_key);
  assign match = valid_r && (key_r == cmd_key);

  assign cur_data.valid   = valid_r;
  assign cur_data.key     = key_r;
  assign cur_data.payload = payload_r;
  assign cur_flags.ge     = ge;
  assign cur_flags.prefix = left_flags.prefix | match;

  // next contents from the broadcast op and the neighbors
  always_comb begin
    valid_nxt   = valid_r;
    key_nxt     = key_r;
    payload_nxt = payload_r;
    case (op)
      CELL_INSERT: begin
        if (!ge) begin
          if (left_flags.ge) begin
            // insertion point: first cell past all equal or greater keys
            valid_nxt   = 1'b1;
            key_nxt     = cmd_key;
            payload_nxt = cmd_payload;
          end else begin
            valid_nxt   = left_data.valid;
            key_nxt     = left_data.key;
            payload_nxt = left_data.payload;
          end
        end
      end
      CELL_REMOVE: begin
        // the first match and everything after it move one step left
        if (cur_flags.prefix) begin
          valid_nxt   = right_data.valid;
          key_nxt     = right_data.key;
          payload_nxt = right_data.payload;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    payload_r <= payload_nxt;
  end

endmodule

// ----- rtl/core/skt_chain.sv -----
// Row of record cells wired to their neighbors.
module skt_chain (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  skt_pkg::cell_op_t                     op,
  input  skt_pkg::key_t                         cmd_key,
  input  skt_pkg::payload_t                     cmd_payload,
  output skt_pkg::cell_data_t [skt_pkg::DEPTH-1:0] cells,
  output logic [skt_pkg::DEPTH-1:0]             match_vec
);
  import skt_pkg::*;

  cell_flags_t [DEPTH-1:0] flags;
  cell_data_t              edge_data;
  cell_flags_t             head_flags;

  // outside the row: empty data; the head sees a "greater" left side
  assign edge_data        = '0;
  assign head_flags.ge     = 1'b1;
  assign head_flags.prefix = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_data_t  l_data, r_data;
    cell_flags_t l_flags;

    if (i == 0) begin : g_head
      assign l_data  = edge_data;
      assign l_flags = head_flags;
    end else begin : g_mid
      assign l_data  = cells[i-1];
      assign l_flags = flags[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_data = edge_data;
    end else begin : g_body
      assign r_data = cells[i+1];
    end

    skt_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .op          (op),
      .cmd_key     (cmd_key),
      .cmd_payload (cmd_payload),
      .left_data   (l_data),
      .left_flags  (l_flags),
      .right_data  (r_data),
      .cur_data    (cells[i]),
      .cur_flags   (flags[i]),
      .match       (match_vec[i])
    );
  end

endmodule

// ----- rtl/core/sorted_key_table.sv -----
// Sorted key table: up to DEPTH records kept in descending key order.
//
// Input channel (in_*): one word per command. tuser carries the kind (insert,
// find, delete, dump), tdata the key and the payload. Output channel (out_*):
// result words with status in tuser, key and payload in tdata, tlast on the
// final result of a command.
// Commands run one at a time; in_tready is high while no command is at work,
// also while the final result still sits in the output register.
// Insert: the row is written after accept, unless full, and one result is given;
//   the cells from the insertion point on shift right together in that write.
// Delete: the first match is removed by a left shift of the row, again while
//   any match remains, then one result is given.
// Find: the scan pointer steps through table positions up to the last match,
//   one result per match. Dump: one result per record.
// Reset empties the table at once (valid bits in each cell).
// When out_tready is low the current result holds in the output register
// and the command waits before its next result; nothing is dropped.
module sorted_key_table (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [skt_pkg::TDATA_BITS-1:0] in_tdata,   // key, payload, zero fill
  input  logic [1:0]                     in_tuser,   // kind
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [skt_pkg::TDATA_BITS-1:0] out_tdata,  // key_out, payload_out, zero fill
  output logic [1:0]                     out_tuser,  // status
  output logic                           out_tlast
);
  import skt_pkg::*;

  state_t   state_r, state_nxt;
  kind_t    kind_r, kind_nxt;
  key_t     key_r, key_nxt;
  payload_t payload_r, payload_nxt;
  idx_t     idx_r, idx_nxt;
  logic     hit_r, hit_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [TDATA_BITS-1:0] out_data_r, out_data_nxt;
  status_t               out_status_r, out_status_nxt;
  logic                  out_last_r, out_last_nxt;

  cell_op_t                 cell_op;
  cell_data_t [DEPTH-1:0]   cells;
  logic [DEPTH-1:0]         match_vec;
  logic [DEPTH-1:0]         valid_vec;
  logic                     in_acc, out_free, any_match, full, at_end;
  idx_t                     idx_plus;
  cell_data_t               sel_cell;
  logic                     next_match, next_valid;

  skt_chain u_chain (
    .clk         (clk),
    .rst_n       (rst_n),
    .op          (cell_op),
    .cmd_key     (key_r),
    .cmd_payload (payload_r),
    .cells       (cells),
    .match_vec   (match_vec)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_valid
    assign valid_vec[i] = cells[i].valid;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign any_match  = |match_vec;
  assign full       = valid_vec[DEPTH-1];
  assign at_end     = (idx_r == IDX_BITS'(DEPTH - 1));
  assign idx_plus   = idx_r + 1'b1;
  assign sel_cell   = cells[idx_r];
  assign next_match = at_end ? 1'b0 : match_vec[idx_plus];
  assign next_valid = at_end ? 1'b0 : valid_vec[idx_plus];

  // command sequencer and result word
  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    key_nxt        = key_r;
    payload_nxt    = payload_r;
    idx_nxt        = idx_r;
    hit_nxt        = hit_r;
    cell_op        = CELL_HOLD;
    out_valid_nxt  = out_tready ? 1'b0 : out_valid_r;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          kind_nxt    = kind_t'(in_tuser);
          key_nxt     = in_tdata[KEY_BITS-1:0];
          payload_nxt = in_tdata[KEY_BITS +: PAYLOAD_BITS];
          idx_nxt     = '0;
          hit_nxt     = 1'b0;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (kind_r)
          KIND_INSERT: begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b1;
              if (full) begin
                out_status_nxt = STATUS_FULL;
                out_data_nxt   = '0;
              end else begin
                cell_op        = CELL_INSERT;
                out_status_nxt = STATUS_OK;
                out_data_nxt   = TDATA_BITS'({payload_r, key_r});
              end
              state_nxt = ST_IDLE;
            end
          end
          KIND_FIND: begin
            if (!any_match) begin
              if (out_free) begin
                out_valid_nxt  = 1'b1;
                out_last_nxt   = 1'b1;
                out_status_nxt = STATUS_NOT_FOUND;
                out_data_nxt   = '0;
                state_nxt      = ST_IDLE;
              end
            end else if (!match_vec[idx_r]) begin
              idx_nxt = idx_plus;
            end else if (out_free) begin
              // matches sit side by side, so the run ends at a non-match
              out_valid_nxt  = 1'b1;
              out_last_nxt   = !next_match;
              out_status_nxt = STATUS_OK;
              out_data_nxt   = TDATA_BITS'({sel_cell.payload, sel_cell.key});
              idx_nxt        = idx_plus;
              if (!next_match) begin
                state_nxt = ST_IDLE;
              end
            end
          end
          KIND_DELETE: begin
            if (any_match) begin
              cell_op = CELL_REMOVE;
              hit_nxt = 1'b1;
            end else if (out_free) begin
              out_valid_nxt  = 1'b1;
              out_last_nxt   = 1'b1;
              out_status_nxt = hit_r ? STATUS_OK : STATUS_NOT_FOUND;
              out_data_nxt   = '0;
              state_nxt      = ST_IDLE;
            end
          end
          KIND_DUMP: begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              if (!valid_vec[0]) begin
                out_last_nxt   = 1'b1;
                out_status_nxt = STATUS_EMPTY;
                out_data_nxt   = '0;
                state_nxt      = ST_IDLE;
              end else begin
                out_last_nxt   = !next_valid;
                out_status_nxt = STATUS_OK;
                out_data_nxt   = TDATA_BITS'({sel_cell.payload, sel_cell.key});
                idx_nxt        = idx_plus;
                if (!next_valid) begin
                  state_nxt = ST_IDLE;
                end
              end
            end
          end
          default: ;
        endcase
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // command and result payload registers
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    key_r        <= key_nxt;
    payload_r    <= payload_nxt;
    idx_r        <= idx_nxt;
    hit_r        <= hit_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  // valid records always form a run from the head of the row
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + 1'b1)) == '0)
    else $error("valid cells not contiguous from the head");

  // the row changes only while a command is at work
  a_op_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_op != CELL_HOLD) |-> (state_r == ST_EXEC))
    else $error("cell op outside a command");

  // an insert never pushes a record out of a full row
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_op == CELL_INSERT) |-> !full)
    else $error("insert into full row");

  // a result is loaded only into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> ($stable(out_data_r) && $stable(out_last_r)))
    else $error("stalled result overwritten");

endmodule
